@@ hw/rtl/ipcidr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipcidr_pkg
// Types and constants shared by the IPv4 text parser and the prefix cell chain.
// ----------------------------------------------------------------------------
package ipcidr_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int TABLE_ENTRIES_MAX = 64;
    localparam int ENTRY_ID_W        = 6;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_CHAR  = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [9:0] OCTET_MAX  = 10'd255;
    localparam logic [2:0] OCTETS     = 3'd4;
    localparam logic [1:0] DIGITS_MAX = 2'd3;
    localparam logic [5:0] PLEN_MAX   = 6'd32;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  entry_index;
        logic [31:0] entry_base;
        logic [5:0]  entry_prefix_len;
        logic        entry_enable;
        logic [7:0]  char_code;
    } t_req;

    typedef struct packed {
        logic        parse_ok;
        logic [31:0] ip_address;
        logic        trusted;
    } t_result;

    // table write broadcast to every cell
    typedef struct packed {
        logic        strobe;
        logic [2:0]  index;
        logic [31:0] base;
        logic [5:0]  len;
        logic        used;
    } t_tbl_wr;

    // lookup that walks the cell chain
    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
        logic        hit;
    } t_probe;

endpackage

@@ hw/rtl/ipcidr_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipcidr_req_if
// Request channel: valid/ready handshake with one request beat as payload.
// ----------------------------------------------------------------------------
interface ipcidr_req_if;
    logic               valid;
    logic               ready;
    ipcidr_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/ipcidr_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipcidr_res_if
// Result channel: valid/ready handshake with one lookup result as payload.
// ----------------------------------------------------------------------------
interface ipcidr_res_if;
    logic                valid;
    logic                ready;
    ipcidr_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/ipv4_text_cidr_trust_check_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_text_cidr_trust_check_core
// Character and table-write beats: one per cycle while requests are not held off,
// no result. End beat: the probe walks the slot chain one cell per cycle unless the
// chain stalls, then the result is registered; requests are held off until it is
// loaded, and longer while the previous result still waits on the output.
// Synchronous reset empties the table and clears the parser and output.
// ----------------------------------------------------------------------------
module ipv4_text_cidr_trust_check_core #(
    parameter int TABLE_ENTRIES = ipcidr_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ipcidr_req_if.sink     i_req,
    ipcidr_res_if.source   o_res
);

    logic                accept;
    logic                adv;
    logic                r_busy;
    logic                r_out_valid;
    ipcidr_pkg::t_result r_out;
    logic                load_out;
    ipcidr_pkg::t_tbl_wr wr;

    logic                pv [0:TABLE_ENTRIES];
    ipcidr_pkg::t_probe  probe [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] pv_vec;

    assign i_req.ready = !r_busy;
    assign accept      = i_req.valid && !r_busy;

    assign wr.strobe = accept && (i_req.data.req_type == ipcidr_pkg::REQ_WRITE);
    assign wr.index  = i_req.data.entry_index;
    assign wr.base   = i_req.data.entry_base;
    assign wr.len    = i_req.data.entry_prefix_len;
    assign wr.used   = i_req.data.entry_enable;

    ipcidr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_req         (i_req.data),
        .o_probe_valid (pv[0]),
        .o_probe       (probe[0])
    );

    // whole chain stalls while the finished probe cannot leave
    assign load_out = pv[TABLE_ENTRIES] && (!r_out_valid || o_res.ready);
    assign adv      = !(pv[TABLE_ENTRIES] && !load_out);

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ipcidr_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_wr          (wr),
            .i_adv         (adv),
            .i_probe_valid (pv[g]),
            .i_probe       (probe[g]),
            .o_probe_valid (pv[g+1]),
            .o_probe       (probe[g+1])
        );
        assign pv_vec[g] = pv[g+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pv[0]) begin
                r_busy <= 1'b1;
            end else if (load_out) begin
                r_busy <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.parse_ok   <= probe[TABLE_ENTRIES].ok;
            r_out.ip_address <= probe[TABLE_ENTRIES].addr;
            r_out.trusted    <= probe[TABLE_ENTRIES].hit;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

`ifndef NO_ASSERTIONS
    a_one_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(pv_vec))
        else $error("more than one probe in the cell chain");

    a_idle_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (pv_vec == '0))
        else $error("probe in chain while not busy");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pv[0] |=> r_busy)
        else $error("end beat did not hold off requests");

    a_trust_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.trusted) |-> r_out.parse_ok)
        else $error("trusted result without a valid address");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.parse_ok) |-> (r_out.ip_address == 32'd0))
        else $error("rejected address not zero");
`endif

endmodule

@@ hw/rtl/ipcidr_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipcidr_parser
// Dotted-quad text parser; on the end beat it launches a probe into the chain.
// ----------------------------------------------------------------------------
module ipcidr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  ipcidr_pkg::t_req    i_req,
    output logic                o_probe_valid,
    output ipcidr_pkg::t_probe  o_probe
);

    logic [2:0]  r_cnt, n_cnt;
    logic [1:0]  r_dig, n_dig;
    logic [9:0]  r_val, n_val;
    logic [31:0] r_acc, n_acc;
    logic        r_err, n_err;

    logic        is_digit;
    logic        is_dot;
    logic [9:0]  dval;
    logic        tok_bad;
    logic        fin_err;
    logic [2:0]  fin_cnt;
    logic [31:0] fin_acc;
    logic        fin_ok;

    assign is_digit = (i_req.char_code >= ipcidr_pkg::CHAR_ZERO) &&
                      (i_req.char_code <= ipcidr_pkg::CHAR_NINE);
    assign is_dot   = (i_req.char_code == ipcidr_pkg::CHAR_DOT);
    assign dval     = {2'b00, i_req.char_code - ipcidr_pkg::CHAR_ZERO};
    assign tok_bad  = (r_val > ipcidr_pkg::OCTET_MAX) || (r_cnt >= ipcidr_pkg::OCTETS);

    // close a pending token at the end beat
    always_comb begin
        fin_err = r_err;
        fin_cnt = r_cnt;
        fin_acc = r_acc;
        if (!r_err && r_dig != 2'd0) begin
            if (tok_bad) begin
                fin_err = 1'b1;
            end else begin
                fin_acc = {r_acc[23:0], r_val[7:0]};
                fin_cnt = r_cnt + 3'd1;
            end
        end
        fin_ok = !fin_err && (fin_cnt == ipcidr_pkg::OCTETS);
    end

    always_comb begin
        n_cnt = r_cnt;
        n_dig = r_dig;
        n_val = r_val;
        n_acc = r_acc;
        n_err = r_err;
        if (i_accept) begin
            case (i_req.req_type)
                ipcidr_pkg::REQ_CHAR: begin
                    if (!r_err) begin
                        if (is_digit) begin
                            if (r_cnt >= ipcidr_pkg::OCTETS || r_dig >= ipcidr_pkg::DIGITS_MAX) begin
                                n_err = 1'b1;
                            end else begin
                                n_val = {r_val[6:0], 3'b000} + {r_val[8:0], 1'b0} + dval;
                                n_dig = r_dig + 2'd1;
                            end
                        end else if (is_dot) begin
                            if (r_dig == 2'd0) begin
                                n_err = 1'b1;
                            end else begin
                                if (tok_bad) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_acc = {r_acc[23:0], r_val[7:0]};
                                    n_cnt = r_cnt + 3'd1;
                                end
                                n_dig = 2'd0;
                                n_val = 10'd0;
                            end
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                end
                ipcidr_pkg::REQ_END: begin
                    n_cnt = 3'd0;
                    n_dig = 2'd0;
                    n_val = 10'd0;
                    n_acc = 32'd0;
                    n_err = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_dig <= 2'd0;
            r_val <= 10'd0;
            r_acc <= 32'd0;
            r_err <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_dig <= n_dig;
            r_val <= n_val;
            r_acc <= n_acc;
            r_err <= n_err;
        end
    end

    assign o_probe_valid = i_accept && (i_req.req_type == ipcidr_pkg::REQ_END);
    assign o_probe.ok    = fin_ok;
    assign o_probe.addr  = fin_ok ? fin_acc : 32'd0;
    assign o_probe.hit   = 1'b0;

endmodule

@@ hw/rtl/ipcidr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipcidr_cell
// One table slot: holds base, length and enable, and checks a passing probe.
// ----------------------------------------------------------------------------
module ipcidr_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ipcidr_pkg::t_tbl_wr i_wr,
    input  logic                i_adv,
    input  logic                i_probe_valid,
    input  ipcidr_pkg::t_probe  i_probe,
    output logic                o_probe_valid,
    output ipcidr_pkg::t_probe  o_probe
);

    localparam logic [ipcidr_pkg::ENTRY_ID_W-1:0] ID = ipcidr_pkg::ENTRY_ID_W'(CELL_ID);

    logic [31:0] r_base;
    logic [5:0]  r_len;
    logic        r_used;
    logic        r_pv;
    ipcidr_pkg::t_probe r_probe;

    logic        sel;
    logic [31:0] mask;
    logic        match;

    assign sel   = i_wr.strobe &&
                   (ID == {{(ipcidr_pkg::ENTRY_ID_W-3){1'b0}}, i_wr.index});
    // shift by 32 or more leaves zero, so a full-length mask is all ones
    assign mask  = ~(ipcidr_pkg::ALL_ONES >> r_len);
    assign match = r_used && (r_len <= ipcidr_pkg::PLEN_MAX) &&
                   (((r_base ^ i_probe.addr) & mask) == 32'd0);

    always_ff @(posedge i_clk) begin
        if (sel) begin
            r_base <= i_wr.base;
            r_len  <= i_wr.len;
        end
        if (i_adv) begin
            r_probe.ok   <= i_probe.ok;
            r_probe.addr <= i_probe.addr;
            r_probe.hit  <= i_probe.hit || (i_probe.ok && match);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            if (sel) begin
                r_used <= i_wr.used;
            end
            if (i_adv) begin
                r_pv <= i_probe_valid;
            end
        end
    end

    assign o_probe_valid = r_pv;
    assign o_probe       = r_probe;

endmodule

@@ bench/ipv4_text_cidr_trust_check_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_text_cidr_trust_check_core_tb
// Feeds dotted-quad address text, prefix table writes and unused request codes
// through the request channel, keeps its own parser and prefix table, and
// checks every lookup result field by field against that in arrival order.
// ----------------------------------------------------------------------------
module ipv4_text_cidr_trust_check_core_tb;

    localparam int NUM_SLOTS = ipcidr_pkg::TABLE_ENTRIES_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_BEATS = 460;
    localparam int MIN_RANDOM_LOOKUPS = 32;
    localparam int LIMIT_NS = 2_000_000;

    logic i_clk;
    logic i_rst_n;

    ipcidr_req_if req_bus ();
    ipcidr_res_if res_bus ();

    ipv4_text_cidr_trust_check_core #(
        .TABLE_ENTRIES(NUM_SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    // shadow prefix table and parser
    logic [31:0] slot_base [NUM_SLOTS];
    logic [5:0]  slot_len  [NUM_SLOTS];
    bit          slot_used [NUM_SLOTS];
    int          octet_cnt;
    int          digit_cnt;
    int          octet_acc;
    logic [31:0] addr_acc;
    bit          parse_err;

    ipcidr_pkg::t_result pending_lookups [$];
    logic [7:0]  text_buf [$];

    int mismatch_count;
    int lookups_checked;
    int lookups_predicted;
    int trusted_count;
    int rejected_count;
    int table_writes;
    int active_beats;
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_stall_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("ipv4_text_cidr_trust_check_core verification failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [31:0] prefix_mask(int len);
        if (len == 0) return 32'h0;
        return ipcidr_pkg::ALL_ONES << (32 - len);
    endfunction

    function automatic bit slot_hit(int s, logic [31:0] addr);
        logic [31:0] m;
        if (!slot_used[s] || slot_len[s] > ipcidr_pkg::PLEN_MAX) return 1'b0;
        m = prefix_mask(int'(slot_len[s]));
        return (slot_base[s] & m) == (addr & m);
    endfunction

    function automatic void close_octet();
        if (octet_acc > int'(ipcidr_pkg::OCTET_MAX) ||
            octet_cnt >= int'(ipcidr_pkg::OCTETS)) begin
            parse_err = 1'b1;
        end else begin
            addr_acc = {addr_acc[23:0], 8'(octet_acc)};
            octet_cnt++;
        end
        digit_cnt = 0;
        octet_acc = 0;
    endfunction

    function automatic void clear_parse();
        octet_cnt = 0;
        digit_cnt = 0;
        octet_acc = 0;
        addr_acc  = '0;
        parse_err = 1'b0;
    endfunction

    // advance the shadow state by one accepted beat, queue the lookup on an end beat
    function automatic void parse_and_lookup(ipcidr_pkg::t_req r);
        ipcidr_pkg::t_result res;
        logic [7:0] c;
        c = r.char_code;
        case (r.req_type)
            ipcidr_pkg::REQ_WRITE: begin
                if (int'(r.entry_index) < NUM_SLOTS) begin
                    slot_base[r.entry_index] = r.entry_base;
                    slot_len[r.entry_index]  = r.entry_prefix_len;
                    slot_used[r.entry_index] = r.entry_enable;
                end
                table_writes++;
                active_beats++;
            end
            ipcidr_pkg::REQ_CHAR: begin
                if (!parse_err) begin
                    active_beats++;
                    if (c >= ipcidr_pkg::CHAR_ZERO && c <= ipcidr_pkg::CHAR_NINE) begin
                        if (octet_cnt >= int'(ipcidr_pkg::OCTETS) ||
                            digit_cnt >= int'(ipcidr_pkg::DIGITS_MAX)) begin
                            parse_err = 1'b1;
                        end else begin
                            octet_acc = octet_acc * 10 + int'(c - ipcidr_pkg::CHAR_ZERO);
                            digit_cnt++;
                        end
                    end else if (c == ipcidr_pkg::CHAR_DOT) begin
                        if (digit_cnt == 0) parse_err = 1'b1;
                        else close_octet();
                    end else begin
                        parse_err = 1'b1;
                    end
                end
            end
            ipcidr_pkg::REQ_END: begin
                if (!parse_err && digit_cnt != 0) close_octet();
                res = '0;
                res.parse_ok = !parse_err && octet_cnt == int'(ipcidr_pkg::OCTETS);
                if (res.parse_ok) begin
                    res.ip_address = addr_acc;
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        if (slot_hit(s, addr_acc)) res.trusted = 1'b1;
                    end
                end
                if (res.trusted) trusted_count++;
                if (!res.parse_ok) rejected_count++;
                pending_lookups.push_back(res);
                lookups_predicted++;
                active_beats++;
                clear_parse();
            end
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endfunction

    function automatic ipcidr_pkg::t_req random_beat(logic [1:0] kind);
        logic [63:0] rnd;
        ipcidr_pkg::t_req r;
        rnd = {$urandom, $urandom};
        r = rnd[$bits(ipcidr_pkg::t_req)-1:0];
        r.req_type = kind;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        ipcidr_pkg::t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_lookups.size() == 0) begin
                note_mismatch($sformatf("result with nothing expected: ok=%0b addr=%h trusted=%0b",
                    res_bus.data.parse_ok, res_bus.data.ip_address, res_bus.data.trusted));
            end else begin
                want = pending_lookups.pop_front();
                lookups_checked++;
                if (res_bus.data.parse_ok !== want.parse_ok ||
                    res_bus.data.ip_address !== want.ip_address ||
                    res_bus.data.trusted !== want.trusted) begin
                    note_mismatch($sformatf(
                        "lookup %0d: ok exp %0b got %0b, addr exp %h got %h, trusted exp %0b got %0b",
                        lookups_checked, want.parse_ok, res_bus.data.parse_ok,
                        want.ip_address, res_bus.data.ip_address,
                        want.trusted, res_bus.data.trusted));
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        res_bus.ready = 1'b0;
        rx_stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_stall_left > 0) begin
                res_bus.ready <= 1'b0;
                rx_stall_left--;
            end else begin
                res_bus.ready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
            end
        end
    end

    // one request beat; valid stays high when the next beat follows without a gap
    task automatic send_beat(ipcidr_pkg::t_req r);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= r;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        parse_and_lookup(r);
    endtask

    task automatic wait_all_results();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_lookups.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_slot(int idx, logic [31:0] base, int len, bit en);
        ipcidr_pkg::t_req r;
        r = random_beat(ipcidr_pkg::REQ_WRITE);
        r.entry_index      = idx[2:0];
        r.entry_base       = base;
        r.entry_prefix_len = len[5:0];
        r.entry_enable     = en;
        send_beat(r);
    endtask

    task automatic send_text();
        ipcidr_pkg::t_req r;
        foreach (text_buf[i]) begin
            r = random_beat(ipcidr_pkg::REQ_CHAR);
            r.char_code = text_buf[i];
            send_beat(r);
        end
        send_beat(random_beat(ipcidr_pkg::REQ_END));
    endtask

    function automatic void set_text(string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endfunction

    task automatic send_string(string s);
        set_text(s);
        send_text();
    endtask

    // dotted quad text with optional leading zeros and trailing dot
    function automatic void build_text(logic [31:0] addr);
        int v;
        int ndig;
        int width;
        text_buf.delete();
        for (int o = 3; o >= 0; o--) begin
            v = int'(addr[8*o +: 8]);
            ndig = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
            width = ($urandom_range(0, 4) == 0) ? $urandom_range(ndig, 3) : ndig;
            if (width >= 3) text_buf.push_back(ipcidr_pkg::CHAR_ZERO + 8'(v / 100));
            if (width >= 2) text_buf.push_back(ipcidr_pkg::CHAR_ZERO + 8'((v / 10) % 10));
            text_buf.push_back(ipcidr_pkg::CHAR_ZERO + 8'(v % 10));
            if (o != 0) text_buf.push_back(ipcidr_pkg::CHAR_DOT);
        end
        if ($urandom_range(0, 6) == 0) text_buf.push_back(ipcidr_pkg::CHAR_DOT);
    endfunction

    function automatic void mutate_text();
        int pos;
        int keep;
        pos = (text_buf.size() == 0) ? 0 : $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 6))
            0: if (text_buf.size() > 0) text_buf[pos] = 8'($urandom_range(0, 255));
            1: text_buf.insert(pos, 8'($urandom_range(0, 255)));
            2: if (text_buf.size() > 0) text_buf.delete(pos);
            3: begin
                text_buf.push_back(ipcidr_pkg::CHAR_DOT);
                text_buf.push_back(ipcidr_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
            4: text_buf.insert(pos, ipcidr_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            5: text_buf.insert(pos, ipcidr_pkg::CHAR_DOT);
            default: begin
                keep = $urandom_range(0, text_buf.size());
                while (text_buf.size() > keep) void'(text_buf.pop_back());
            end
        endcase
    endfunction

    function automatic int pick_len();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 32;
            2: return $urandom_range(33, 63);
            default: return $urandom_range(1, 31);
        endcase
    endfunction

    task automatic test_table_rules();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_slot(0, 32'h0A00_0000, 8, 1'b1);
        write_slot(1, 32'hC0A8_0107, 32, 1'b1);
        write_slot(2, 32'h0000_0000, 0, 1'b0);
        write_slot(3, 32'h0000_0000, 40, 1'b1);
        write_slot(7, ipcidr_pkg::ALL_ONES, 63, 1'b1);
        send_string("10.1.2.3");
        send_string("192.168.1.7");
        send_string("192.168.1.8");
        send_string("0.0.0.0");
        send_string("255.255.255.255");
        // prefix length zero takes every valid address
        write_slot(2, 32'h0000_0000, 0, 1'b1);
        send_string("8.8.8.8");
        // unused request code with every field bit set must leave no trace
        send_beat('1);
        write_slot(2, 32'h0000_0000, 0, 1'b0);
        send_string("8.8.8.8");
    endtask

    task automatic test_parse_cases();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_string("10.0.0.0.");
        send_string("000.01.9.255");
        send_string(".1.2.3");
        send_string("1..2.3.4");
        send_string("1.2.3.4..");
        send_string("1.2.3.4.5");
        send_string("1234.1.1.1");
        send_string("256.1.1.1");
        send_string("1.2.3.999");
        send_string("1.2.3");
        send_string("1.2.a.4");
        send_string("");
        send_string("1:2.3./");
        set_text("9.9.9.9");
        text_buf.push_back(8'h00);
        send_text();
        set_text("10.9.9.9");
        text_buf.insert(2, 8'hFF);
        send_text();
    endtask

    task automatic test_random_traffic();
        int first_beat;
        int first_lookup;
        int addr_no;
        int s;
        logic [31:0] a;
        logic [31:0] m;
        first_beat   = active_beats;
        first_lookup = lookups_predicted;
        addr_no      = 0;
        while (active_beats - first_beat < RANDOM_BEATS ||
               lookups_predicted - first_lookup < MIN_RANDOM_LOOKUPS) begin
            if (addr_no % 8 == 0) begin
                tx_idle_en = $urandom_range(0, 3) != 0;
                rx_idle_en = $urandom_range(0, 3) != 0;
            end
            // hold the sender until the result side has caught up
            if (addr_no % 25 == 24) wait_all_results();
            if ($urandom_range(0, 4) == 0)
                write_slot($urandom_range(0, NUM_SLOTS - 1), $urandom, pick_len(),
                           $urandom_range(0, 6) != 0);
            if ($urandom_range(0, 24) == 0) send_beat(random_beat(REQ_UNUSED));
            s = $urandom_range(0, NUM_SLOTS - 1);
            if ($urandom_range(0, 1) == 1 && slot_len[s] <= ipcidr_pkg::PLEN_MAX) begin
                m = prefix_mask(int'(slot_len[s]));
                a = (slot_base[s] & m) | ($urandom & ~m);
            end else begin
                a = $urandom;
            end
            build_text(a);
            if ($urandom_range(0, 3) == 0) mutate_text();
            send_text();
            addr_no++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_base[s] = '0;
            slot_len[s]  = '0;
            slot_used[s] = 1'b0;
        end
        clear_parse();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_table_rules();
        test_parse_cases();
        test_random_traffic();

        wait_all_results();
        repeat (2 * NUM_SLOTS + 4) @(posedge i_clk);

        $display("covered %0d lookups (%0d trusted, %0d rejected texts) over %0d active beats",
                 lookups_checked, trusted_count, rejected_count, active_beats);
        $display("with %0d prefix table writes and %0d mismatches", table_writes, mismatch_count);
        if (mismatch_count == 0 && pending_lookups.size() == 0) begin
            $display("ipv4_text_cidr_trust_check_core verification clean");
        end else begin
            $display("ipv4_text_cidr_trust_check_core verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ipcidr_pkg.sv
hw/rtl/ipcidr_req_if.sv
hw/rtl/ipcidr_res_if.sv
hw/rtl/ipcidr_parser.sv
hw/rtl/ipcidr_cell.sv
hw/rtl/ipv4_text_cidr_trust_check_core.sv
bench/ipv4_text_cidr_trust_check_core_tb.sv
